// File: hw/rtl/iads_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iads_pkg: shared types and codes for the indexed array unit
// Request and response payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package iads_pkg;

	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_DELETE = 3'd2;
	localparam logic [2:0] MODE_READ   = 3'd3;
	localparam logic [2:0] MODE_FIND   = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	localparam logic signed [31:0] READ_MISS = -32'sd1;

	typedef struct packed {
		logic [2:0]         mode;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [5:0]         found_position;
		logic [1:0]         status;
		logic [6:0]         element_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MOVE,
		ST_FLUSH,
		ST_PUT,
		ST_SEARCH,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/indexed_array_insert_delete_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_search_unit: ordered word array with edit ops
// Append, insert, delete, read and find on a fixed-capacity array in one RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready is high only while the sequencer
// is idle. Insert and delete shift the words behind the index one by one, and
// find scans from index 0 until a match or the end of the array. The single RAM
// read port walks one stored word per cycle. The response register frees the
// sequencer as soon as the response is loaded.
module indexed_array_insert_delete_search_unit #(
	parameter int CAPACITY = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire iads_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output iads_pkg::rsp_t     rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	logic signed [31:0] store_q [CAPACITY];
	logic signed [31:0] rdata_q;

	iads_pkg::state_t   state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rem_q;
	logic [AW-1:0]      src_q, dst_q, pos_q, chk_idx_q;
	logic               mv_q, chk_q;
	logic [2:0]         mode_q;
	logic signed [31:0] val_q, rd_val_q;
	logic [5:0]         found_q;
	logic [1:0]         status_q;
	iads_pkg::rsp_t     rsp_q;
	logic               rsp_valid_q;

	logic               fire, full, pos_le, pos_lt, match, rsp_load;
	logic [CMP_W-1:0]   pos_x, cnt_x;
	logic [CNT_W-1:0]   ins_moves, del_moves;
	logic               mem_we;
	logic [AW-1:0]      mem_wa, rd_addr;
	logic signed [31:0] mem_wd;

	assign req_ready = (state_q == iads_pkg::ST_IDLE);
	assign fire      = req_valid && req_ready;
	assign pos_x     = CMP_W'(req.position);
	assign cnt_x     = CMP_W'(cnt_q);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign pos_le    = (pos_x <= cnt_x);
	assign pos_lt    = (pos_x < cnt_x);
	assign ins_moves = CNT_W'(cnt_x - pos_x);
	assign del_moves = CNT_W'(cnt_x - pos_x - CMP_W'(1));
	assign match     = (rdata_q == val_q);
	assign rsp_load  = (state_q == iads_pkg::ST_RESP) && (!rsp_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iads_pkg::ST_IDLE: begin
				if (fire) begin
					case (req.mode)
						iads_pkg::MODE_INSERT: begin
							if (!pos_le || full)
								state_d = iads_pkg::ST_RESP;
							else if (ins_moves == '0)
								state_d = iads_pkg::ST_PUT;
							else
								state_d = iads_pkg::ST_MOVE;
						end
						iads_pkg::MODE_DELETE: begin
							if (!pos_lt || del_moves == '0)
								state_d = iads_pkg::ST_RESP;
							else
								state_d = iads_pkg::ST_MOVE;
						end
						iads_pkg::MODE_READ:
							state_d = pos_lt ? iads_pkg::ST_READ : iads_pkg::ST_RESP;
						iads_pkg::MODE_FIND:
							state_d = (cnt_q == '0) ? iads_pkg::ST_RESP : iads_pkg::ST_SEARCH;
						default:
							state_d = iads_pkg::ST_RESP;
					endcase
				end
			end
			iads_pkg::ST_READ:  state_d = iads_pkg::ST_RESP;
			iads_pkg::ST_MOVE: begin
				if (rem_q == CNT_W'(1))
					state_d = iads_pkg::ST_FLUSH;
			end
			iads_pkg::ST_FLUSH:
				state_d = (mode_q == iads_pkg::MODE_INSERT) ? iads_pkg::ST_PUT
					: iads_pkg::ST_RESP;
			iads_pkg::ST_PUT:   state_d = iads_pkg::ST_RESP;
			iads_pkg::ST_SEARCH: begin
				if ((chk_q && match) || rem_q == '0)
					state_d = iads_pkg::ST_RESP;
			end
			iads_pkg::ST_RESP: begin
				if (rsp_load)
					state_d = iads_pkg::ST_IDLE;
			end
			default: state_d = iads_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = dst_q;
		mem_wd  = rdata_q;
		rd_addr = src_q;
		unique case (state_q)
			iads_pkg::ST_IDLE: begin
				rd_addr = pos_x[AW-1:0];
				if (fire && req.mode == iads_pkg::MODE_APPEND && !full) begin
					mem_we = 1'b1;
					mem_wa = cnt_q[AW-1:0];
					mem_wd = req.value;
				end
			end
			iads_pkg::ST_MOVE:  mem_we = mv_q;
			iads_pkg::ST_FLUSH: mem_we = 1'b1;
			iads_pkg::ST_PUT: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_wa] <= mem_wd;
		rdata_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iads_pkg::ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			if (fire && req.mode == iads_pkg::MODE_APPEND && !full)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (fire && req.mode == iads_pkg::MODE_DELETE && pos_lt && del_moves == '0)
				cnt_q <= cnt_q - CNT_W'(1);
			else if (state_q == iads_pkg::ST_FLUSH && mode_q == iads_pkg::MODE_DELETE)
				cnt_q <= cnt_q - CNT_W'(1);
			else if (state_q == iads_pkg::ST_PUT)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			iads_pkg::ST_IDLE: begin
				if (fire) begin
					mode_q   <= req.mode;
					pos_q    <= pos_x[AW-1:0];
					val_q    <= req.value;
					status_q <= iads_pkg::STATUS_OK;
					rd_val_q <= '0;
					found_q  <= '0;
					mv_q     <= 1'b0;
					chk_q    <= 1'b0;
					case (req.mode)
						iads_pkg::MODE_APPEND: begin
							if (full)
								status_q <= iads_pkg::STATUS_FULL;
						end
						iads_pkg::MODE_INSERT: begin
							if (!pos_le)
								status_q <= iads_pkg::STATUS_BAD_INDEX;
							else if (full)
								status_q <= iads_pkg::STATUS_FULL;
							src_q <= AW'(cnt_q - CNT_W'(1));
							rem_q <= ins_moves;
						end
						iads_pkg::MODE_DELETE: begin
							if (!pos_lt)
								status_q <= iads_pkg::STATUS_BAD_INDEX;
							src_q <= AW'(pos_x + CMP_W'(1));
							rem_q <= del_moves;
						end
						iads_pkg::MODE_READ: begin
							if (!pos_lt) begin
								status_q <= iads_pkg::STATUS_BAD_INDEX;
								rd_val_q <= iads_pkg::READ_MISS;
							end
						end
						iads_pkg::MODE_FIND: begin
							status_q <= iads_pkg::STATUS_NOT_FOUND;
							src_q    <= '0;
							rem_q    <= cnt_q;
						end
						default: ;
					endcase
				end
			end
			iads_pkg::ST_READ: rd_val_q <= rdata_q;
			iads_pkg::ST_MOVE: begin
				mv_q  <= 1'b1;
				rem_q <= rem_q - CNT_W'(1);
				if (mode_q == iads_pkg::MODE_INSERT) begin
					dst_q <= src_q + AW'(1);
					src_q <= src_q - AW'(1);
				end else begin
					dst_q <= src_q - AW'(1);
					src_q <= src_q + AW'(1);
				end
			end
			iads_pkg::ST_SEARCH: begin
				if (chk_q && match) begin
					status_q <= iads_pkg::STATUS_OK;
					found_q  <= 6'(chk_idx_q);
				end else if (rem_q != '0) begin
					chk_q     <= 1'b1;
					chk_idx_q <= src_q;
					src_q     <= src_q + AW'(1);
					rem_q     <= rem_q - CNT_W'(1);
				end
			end
			iads_pkg::ST_RESP: begin
				if (rsp_load) begin
					rsp_q.read_value     <= rd_val_q;
					rsp_q.found_position <= found_q;
					rsp_q.status         <= status_q;
					rsp_q.element_count  <= 7'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: tb/sv/indexed_array_insert_delete_search_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_search_unit_test: self-checking bench
// Drives append, insert, delete, read and find requests through the unit.
// A short scripted sequence covers the empty, full and bad-index corners.
// Random traffic follows, with the array filling and draining in turns.
// Each response is checked field by field against a pinned value or a local array model.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_search_unit_test;

	localparam int DEPTH = 64;
	localparam int RANDOM_REQUESTS = 900;
	localparam logic [2:0] MODE_NOP_5 = 3'd5;
	localparam logic [2:0] MODE_NOP_6 = 3'd6;
	localparam logic [2:0] MODE_NOP_7 = 3'd7;
	localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

	typedef struct {
		logic [2:0]         mode;
		logic [6:0]         position;
		logic signed [31:0] value;
		int                 copies;
		bit                 pinned;
		iads_pkg::rsp_t     want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	iads_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	iads_pkg::rsp_t rsp;

	logic signed [31:0] words [DEPTH];
	int word_count = 0;
	bit filling = 1'b1;
	iads_pkg::rsp_t due_responses [$];
	int mismatches = 0;
	int burst_left = 0;
	bit calm = 1'b0;
	logic [15:0] ready_pattern = 16'hFFFF;
	logic [5:0] pattern_tick = '0;

	indexed_array_insert_delete_search_unit #(
		.CAPACITY(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic iads_pkg::rsp_t apply_array_op(input iads_pkg::req_t r);
		iads_pkg::rsp_t o;
		int p;
		int j;
		o = '0;
		p = r.position;
		case (r.mode)
			iads_pkg::MODE_APPEND: begin
				if (word_count >= DEPTH) begin
					o.status = iads_pkg::STATUS_FULL;
				end else begin
					words[word_count] = r.value;
					word_count++;
				end
			end
			iads_pkg::MODE_INSERT: begin
				if (p > word_count) begin
					o.status = iads_pkg::STATUS_BAD_INDEX;
				end else if (word_count >= DEPTH) begin
					o.status = iads_pkg::STATUS_FULL;
				end else begin
					for (j = word_count; j > p; j--)
						words[j] = words[j - 1];
					words[p] = r.value;
					word_count++;
				end
			end
			iads_pkg::MODE_DELETE: begin
				if (p >= word_count) begin
					o.status = iads_pkg::STATUS_BAD_INDEX;
				end else begin
					for (j = p; j + 1 < word_count; j++)
						words[j] = words[j + 1];
					word_count--;
				end
			end
			iads_pkg::MODE_READ: begin
				if (p < word_count) begin
					o.read_value = words[p];
				end else begin
					o.read_value = iads_pkg::READ_MISS;
					o.status = iads_pkg::STATUS_BAD_INDEX;
				end
			end
			iads_pkg::MODE_FIND: begin
				o.status = iads_pkg::STATUS_NOT_FOUND;
				for (j = 0; j < word_count; j++) begin
					if (words[j] == r.value) begin
						o.found_position = 6'(j);
						o.status = iads_pkg::STATUS_OK;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		o.element_count = 7'(word_count);
		return o;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5, 6: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic iads_pkg::req_t draw_request();
		iads_pkg::req_t r;
		int roll;
		r.mode = iads_pkg::MODE_APPEND;
		r.position = '0;
		r.value = pick_word();
		if (word_count >= DEPTH)
			filling = 1'b0;
		else if (word_count == 0)
			filling = 1'b1;
		else if ($urandom_range(0, 39) == 0)
			filling = !filling;
		if ($urandom_range(0, 99) < 4) begin
			r.mode = 3'($urandom_range(0, 7));
			r.position = 7'($urandom_range(0, 127));
			r.value = $signed($urandom);
			return r;
		end
		roll = $urandom_range(0, 99);
		if (roll < (filling ? 30 : 8))
			r.mode = iads_pkg::MODE_APPEND;
		else if (roll < (filling ? 55 : 20))
			r.mode = iads_pkg::MODE_INSERT;
		else if (roll < (filling ? 65 : 55))
			r.mode = iads_pkg::MODE_DELETE;
		else if (roll < 82)
			r.mode = iads_pkg::MODE_READ;
		else
			r.mode = iads_pkg::MODE_FIND;
		if ($urandom_range(0, 19) == 0)
			r.position = 7'($urandom_range(0, 127));
		else if (r.mode == iads_pkg::MODE_INSERT)
			r.position = 7'($urandom_range(0, word_count));
		else if (word_count > 0)
			r.position = 7'($urandom_range(0, word_count - 1));
		if (r.mode == iads_pkg::MODE_FIND && word_count > 0 && $urandom_range(0, 1) == 1)
			r.value = words[$urandom_range(0, word_count - 1)];
		return r;
	endfunction

	// hold valid and payload until the request is taken
	task automatic issue(input iads_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		burst_left--;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] want_v);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got_v, want_v);
	endtask

	task automatic check_response(input iads_pkg::rsp_t got);
		iads_pkg::rsp_t want;
		if (due_responses.size() == 0) begin
			flag_mismatch("unrequested response", 32'(got), '0);
			return;
		end
		want = due_responses.pop_front();
		if (got.read_value !== want.read_value)
			flag_mismatch("read_value", got.read_value, want.read_value);
		if (got.found_position !== want.found_position)
			flag_mismatch("found_position", 32'(got.found_position), 32'(want.found_position));
		if (got.status !== want.status)
			flag_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.element_count !== want.element_count)
			flag_mismatch("element_count", 32'(got.element_count), 32'(want.element_count));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_response(rsp);
		pattern_tick <= pattern_tick + 6'd1;
		if (pattern_tick == '0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= 16'hFFFF;
				1: ready_pattern <= 16'($urandom) | 16'h0001;
				2: ready_pattern <= 16'h8001;
				default: ready_pattern <= 16'($urandom | $urandom) | 16'h0001;
			endcase
		end else begin
			ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
		end
		rsp_ready <= ready_pattern[0];
	end

	initial begin
		step_t script [$];
		step_t row;
		iads_pkg::req_t r;
		iads_pkg::rsp_t got;
		int k;
		int n;

		script.push_back('{iads_pkg::MODE_READ, 7'd0, 32'sd0, 1, 1'b1,
			'{iads_pkg::READ_MISS, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd0}});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd0}});
		script.push_back('{iads_pkg::MODE_FIND, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_NOT_FOUND, 7'd0}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd1, 32'sd7, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd0}});
		script.push_back('{MODE_NOP_7, 7'd127, -32'sd1, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd0}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd0, WORD_MAX, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd1}});
		script.push_back('{iads_pkg::MODE_APPEND, 7'd0, WORD_MIN, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd2}});
		script.push_back('{iads_pkg::MODE_READ, 7'd0, 32'sd0, 1, 1'b1,
			'{WORD_MAX, 6'd0, iads_pkg::STATUS_OK, 7'd2}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd1, 32'sd5, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd3}});
		script.push_back('{iads_pkg::MODE_FIND, 7'd0, 32'sd5, 1, 1'b1,
			'{32'sd0, 6'd1, iads_pkg::STATUS_OK, 7'd3}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd3, -32'sd2, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd4}});
		script.push_back('{iads_pkg::MODE_READ, 7'd127, 32'sd0, 1, 1'b1,
			'{iads_pkg::READ_MISS, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd4}});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd4, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd4}});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd3}});
		script.push_back('{MODE_NOP_5, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd3}});
		script.push_back('{MODE_NOP_6, 7'd64, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd3}});
		script.push_back('{iads_pkg::MODE_APPEND, 7'd0, 32'sd1000, 61, 1'b0, '0});
		script.push_back('{iads_pkg::MODE_APPEND, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_FULL, 7'd64}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd64, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_FULL, 7'd64}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd65, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_BAD_INDEX, 7'd64}});
		script.push_back('{iads_pkg::MODE_INSERT, 7'd0, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_FULL, 7'd64}});
		script.push_back('{iads_pkg::MODE_FIND, 7'd0, 32'sd1060, 1, 1'b1,
			'{32'sd0, 6'd63, iads_pkg::STATUS_OK, 7'd64}});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd63, 32'sd0, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_OK, 7'd63}});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd1, 32'sd0, 20, 1'b0, '0});
		script.push_back('{iads_pkg::MODE_DELETE, 7'd0, 32'sd0, 42, 1'b0, '0});
		script.push_back('{iads_pkg::MODE_FIND, 7'd0, WORD_MAX, 1, 1'b1,
			'{32'sd0, 6'd0, iads_pkg::STATUS_NOT_FOUND, 7'd1}});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			row = script[i];
			for (k = 0; k < row.copies; k++) begin
				r.mode = row.mode;
				r.position = row.position;
				r.value = row.value + k;
				issue(r);
				got = apply_array_op(r);
				due_responses.push_back(row.pinned ? row.want : got);
			end
		end

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			r = draw_request();
			issue(r);
			due_responses.push_back(apply_array_op(r));
		end

		req_valid <= 1'b0;
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
